>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> design/ftlb_pkg.sv
// ----------------------------------------------------------------------------
// ftlb_pkg
// Shared types and constants of the FIFO-replacement TLB.
// ----------------------------------------------------------------------------
`default_nettype none

package ftlb_pkg;

	localparam int unsigned TLB_DEPTH_DEF = 16;
	localparam int unsigned PAGE_BITS_DEF = 10;
	localparam int unsigned PID_BITS_DEF  = 8;

	localparam int unsigned KIND_W  = 2;
	localparam int unsigned PID_W   = 8;
	localparam int unsigned PAGE_W  = 10;
	localparam int unsigned FRAME_W = 10;
	localparam int unsigned CNT_W   = 32;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0]  CFG_ENABLE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  CFG_ENTRIES = 1'b1;
	localparam logic [CFG_DATA_W-1:0] ENTRIES_RST = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_INVAL  = 2'd2,
		KIND_FLUSH  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} seq_state_t;

	// request completion, sequencer to top level
	typedef struct packed {
		logic               done;
		logic               lookup;
		logic               hit;
		logic [FRAME_W-1:0] frame;
	} fin_t;

endpackage

`default_nettype wire

>>> design/ftlb_ifs.sv
// ----------------------------------------------------------------------------
// ftlb_ifs
// Request and response channels of the TLB.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftlb_req_if;
	logic                          valid;
	logic                          ready;
	logic [ftlb_pkg::KIND_W-1:0]   kind;
	logic [ftlb_pkg::PID_W-1:0]    proc_id;
	logic [ftlb_pkg::PAGE_W-1:0]   page_num;
	logic [ftlb_pkg::FRAME_W-1:0]  frame_in;

	modport source (output valid, kind, proc_id, page_num, frame_in, input ready);
	modport sink (input valid, kind, proc_id, page_num, frame_in, output ready);
endinterface

interface ftlb_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [ftlb_pkg::FRAME_W-1:0]  frame_out;
	logic [ftlb_pkg::CNT_W-1:0]    access_count;
	logic [ftlb_pkg::CNT_W-1:0]    hit_count;

	modport source (output valid, hit, frame_out, access_count, hit_count, input ready);
	modport sink (input valid, hit, frame_out, access_count, hit_count, output ready);
endinterface

`default_nettype wire

>>> design/fifo_tlb_pid_page_unit.sv
// ----------------------------------------------------------------------------
// fifo_tlb_pid_page_unit
// Fully associative TLB keyed by process id and page, FIFO replacement.
// ----------------------------------------------------------------------------
// Entries live in a circular buffer in a single-port-read memory, oldest at
// the head pointer. The sequencer compares one stored entry per cycle, so a
// lookup or insert holds the block while it compares the entries up to and
// including a match (all occupied ones on a miss); an invalidate also moves
// each entry behind the removed one a slot toward the head to close the gap.
// Requests while disabled, flushes and empty-table requests finish in idle.
// One request is in flight at a time; a new request is taken only when no
// response is waiting or the waiting one is taken in the same cycle.
`default_nettype none

module fifo_tlb_pid_page_unit #(
	parameter int unsigned TLB_DEPTH = ftlb_pkg::TLB_DEPTH_DEF,
	parameter int unsigned PAGE_BITS = ftlb_pkg::PAGE_BITS_DEF,
	parameter int unsigned PID_BITS  = ftlb_pkg::PID_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ftlb_req_if.sink                             req,
	ftlb_rsp_if.source                           rsp,
	input  wire logic                            cfg_we,
	input  wire logic [ftlb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ftlb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned CW      = $clog2(TLB_DEPTH + 1);
	localparam int unsigned DW      = ftlb_pkg::CFG_DATA_W;
	localparam int unsigned CMPW    = (CW > DW) ? CW : DW;
	localparam int unsigned PID_EXT = (PID_BITS > ftlb_pkg::PID_W)
		? PID_BITS : ftlb_pkg::PID_W;
	localparam int unsigned PG_EXT  = (PAGE_BITS > ftlb_pkg::PAGE_W)
		? PAGE_BITS : ftlb_pkg::PAGE_W;
	localparam int unsigned NW      = ftlb_pkg::CNT_W;

	logic                          enable_q;
	logic [DW-1:0]                 entries_q;
	logic [CMPW-1:0]               eiu_ext;
	logic [CMPW-1:0]               cap_ext;
	logic [CW-1:0]                 cap;
	logic [PID_EXT-1:0]            pid_ext;
	logic [PG_EXT-1:0]             page_ext;
	logic                          idle, accept;
	ftlb_pkg::fin_t                fin;
	logic [NW-1:0]                 lookups_q, hits_q, lookups_d, hits_d;
	logic                          rsp_valid_q, hit_q;
	logic [ftlb_pkg::FRAME_W-1:0]  frame_q;
	logic [NW-1:0]                 acc_q, hcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			entries_q <= ftlb_pkg::ENTRIES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ftlb_pkg::CFG_ENABLE:  enable_q  <= cfg_wdata[0];
				ftlb_pkg::CFG_ENTRIES: entries_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// capacity clamped to 1..TLB_DEPTH
	assign eiu_ext = CMPW'(entries_q);
	assign cap_ext = (eiu_ext == '0) ? CMPW'(1)
		: (eiu_ext > CMPW'(TLB_DEPTH)) ? CMPW'(TLB_DEPTH) : eiu_ext;
	assign cap     = cap_ext[CW-1:0];

	assign pid_ext  = PID_EXT'(req.proc_id);
	assign page_ext = PG_EXT'(req.page_num);

	assign req.ready = idle && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	ftlb_seq #(
		.TLB_DEPTH(TLB_DEPTH),
		.PAGE_BITS(PAGE_BITS),
		.PID_BITS (PID_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.enable  (enable_q),
		.cap     (cap),
		.op_valid(accept),
		.op_kind (ftlb_pkg::kind_t'(req.kind)),
		.op_pid  (pid_ext[PID_BITS-1:0]),
		.op_page (page_ext[PAGE_BITS-1:0]),
		.op_frame(req.frame_in),
		.idle    (idle),
		.fin     (fin)
	);

	assign lookups_d = (fin.lookup && lookups_q != '1) ? lookups_q + NW'(1) : lookups_q;
	assign hits_d    = (fin.hit && hits_q != '1) ? hits_q + NW'(1) : hits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookups_q   <= '0;
			hits_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin.done) begin
				lookups_q   <= lookups_d;
				hits_q      <= hits_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin.done) begin
			hit_q   <= fin.hit;
			frame_q <= fin.frame;
			acc_q   <= lookups_d;
			hcnt_q  <= hits_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.hit          = hit_q;
	assign rsp.frame_out    = frame_q;
	assign rsp.access_count = acc_q;
	assign rsp.hit_count    = hcnt_q;

endmodule

`default_nettype wire

>>> design/ftlb_entry_ram.sv
// ----------------------------------------------------------------------------
// ftlb_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ftlb_entry_ram #(
	parameter int unsigned DEPTH = ftlb_pkg::TLB_DEPTH_DEF,
	parameter int unsigned DW = ftlb_pkg::PID_BITS_DEF + ftlb_pkg::PAGE_BITS_DEF
		+ ftlb_pkg::FRAME_W,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/ftlb_seq.sv
// ----------------------------------------------------------------------------
// ftlb_seq
// Request sequencer: walks the circular entry store one slot per cycle,
// appends, evicts the oldest and closes gaps on invalidate.
// ----------------------------------------------------------------------------
`default_nettype none

module ftlb_seq #(
	parameter int unsigned TLB_DEPTH = ftlb_pkg::TLB_DEPTH_DEF,
	parameter int unsigned PAGE_BITS = ftlb_pkg::PAGE_BITS_DEF,
	parameter int unsigned PID_BITS  = ftlb_pkg::PID_BITS_DEF,
	localparam int unsigned CW = $clog2(TLB_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         enable,
	input  wire logic [CW-1:0]                cap,
	input  wire logic                         op_valid,
	input  wire ftlb_pkg::kind_t              op_kind,
	input  wire logic [PID_BITS-1:0]          op_pid,
	input  wire logic [PAGE_BITS-1:0]         op_page,
	input  wire logic [ftlb_pkg::FRAME_W-1:0] op_frame,
	output logic                              idle,
	output ftlb_pkg::fin_t                    fin
);

	localparam int unsigned AW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int unsigned SW = CW + 1;
	localparam int unsigned FW = ftlb_pkg::FRAME_W;
	localparam int unsigned EW = PID_BITS + PAGE_BITS + FW;
	localparam logic [SW-1:0] DEPTH_S = SW'(TLB_DEPTH);
	localparam logic [AW-1:0] LAST_A = AW'(TLB_DEPTH - 1);

	ftlb_pkg::seq_state_t state_q, state_d;
	logic [AW-1:0]        head_q, head_d;
	logic [CW-1:0]        count_q, count_d;
	logic [AW-1:0]        idx_q, idx_d;
	logic [AW-1:0]        raddr_q;
	ftlb_pkg::kind_t      kind_q;
	logic [PID_BITS-1:0]  pid_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [FW-1:0]        frame_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic [CW-1:0] idx_inc;
	logic          more, rd_match;

	function automatic logic [AW-1:0] phys(input logic [SW-1:0] s);
		logic [SW-1:0] w;
		w = (s >= DEPTH_S) ? s - DEPTH_S : s;
		return w[AW-1:0];
	endfunction

	ftlb_entry_ram #(
		.DEPTH(TLB_DEPTH),
		.DW   (EW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign idx_inc  = CW'(idx_q) + CW'(1);
	assign more     = idx_inc < count_q;
	assign rd_match = (rdata[EW-1 -: PID_BITS] == pid_q)
		&& (rdata[FW +: PAGE_BITS] == page_q);
	assign idle     = (state_q == ftlb_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftlb_pkg::ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (re) begin
			raddr_q <= raddr;
		end
		if (idle && op_valid) begin
			kind_q  <= op_kind;
			pid_q   <= op_pid;
			page_q  <= op_page;
			frame_q <= op_frame;
		end
	end

	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		count_d = count_q;
		idx_d   = idx_q;
		re      = 1'b0;
		raddr   = head_q;
		we      = 1'b0;
		waddr   = phys(SW'(head_q) + SW'(count_q));
		wdata   = {pid_q, page_q, frame_q};
		fin     = '0;
		case (state_q)
			ftlb_pkg::ST_IDLE: begin
				if (op_valid) begin
					if (!enable) begin
						fin.done = 1'b1;
					end else if (op_kind == ftlb_pkg::KIND_FLUSH) begin
						count_d  = '0;
						fin.done = 1'b1;
					end else if (count_q == '0) begin
						fin.done   = 1'b1;
						fin.lookup = (op_kind == ftlb_pkg::KIND_LOOKUP);
						if (op_kind == ftlb_pkg::KIND_INSERT) begin
							we      = 1'b1;
							waddr   = head_q;
							wdata   = {op_pid, op_page, op_frame};
							count_d = CW'(1);
						end
					end else begin
						re      = 1'b1;
						idx_d   = '0;
						state_d = ftlb_pkg::ST_SCAN;
					end
				end
			end
			ftlb_pkg::ST_SCAN: begin
				if (rd_match || !more) begin
					case (kind_q)
						ftlb_pkg::KIND_LOOKUP: begin
							fin.done   = 1'b1;
							fin.lookup = 1'b1;
							fin.hit    = rd_match;
							fin.frame  = rd_match ? rdata[FW-1:0] : '0;
							state_d    = ftlb_pkg::ST_IDLE;
						end
						ftlb_pkg::KIND_INSERT: begin
							fin.done = 1'b1;
							state_d  = ftlb_pkg::ST_IDLE;
							if (!rd_match) begin
								// new slot follows the youngest; on eviction the
								// head advances past the dropped oldest entries
								we = 1'b1;
								if (count_q >= cap) begin
									head_d  = phys(SW'(head_q)
										+ SW'(count_q - cap + CW'(1)));
									count_d = cap;
								end else begin
									count_d = count_q + CW'(1);
								end
							end
						end
						ftlb_pkg::KIND_INVAL: begin
							if (rd_match && more) begin
								re      = 1'b1;
								raddr   = phys(SW'(head_q) + SW'(idx_inc));
								idx_d   = idx_inc[AW-1:0];
								state_d = ftlb_pkg::ST_SHIFT;
							end else begin
								if (rd_match) begin
									count_d = count_q - CW'(1);
								end
								fin.done = 1'b1;
								state_d  = ftlb_pkg::ST_IDLE;
							end
						end
						default: begin
							fin.done = 1'b1;
							state_d  = ftlb_pkg::ST_IDLE;
						end
					endcase
				end else begin
					re    = 1'b1;
					raddr = phys(SW'(head_q) + SW'(idx_inc));
					idx_d = idx_inc[AW-1:0];
				end
			end
			ftlb_pkg::ST_SHIFT: begin
				// move the entry just read one slot toward the head
				we    = 1'b1;
				waddr = (raddr_q == '0) ? LAST_A : raddr_q - AW'(1);
				wdata = rdata;
				if (more) begin
					re    = 1'b1;
					raddr = phys(SW'(head_q) + SW'(idx_inc));
					idx_d = idx_inc[AW-1:0];
				end else begin
					count_d  = count_q - CW'(1);
					fin.done = 1'b1;
					state_d  = ftlb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ftlb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/ftlb_checker.sv
// ----------------------------------------------------------------------------
// ftlb_checker
// Port-level checks of the TLB, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ftlb_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic                          rsp_hit,
	input wire logic [ftlb_pkg::FRAME_W-1:0]  rsp_frame_out,
	input wire logic [ftlb_pkg::CNT_W-1:0]    rsp_access_count,
	input wire logic [ftlb_pkg::CNT_W-1:0]    rsp_hit_count
);

	// one request in flight: after a request, either its response is up or
	// intake is closed
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, rsp_valid || !req_ready)

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_frame_out) && $stable(rsp_access_count) && $stable(rsp_hit_count))

	`ASSERT_IMPL(a_hits_le_access, clk, arst_n, rsp_valid, rsp_hit_count <= rsp_access_count)

	`ASSERT_IMPL(a_miss_frame_zero, clk, arst_n, rsp_valid && !rsp_hit, rsp_frame_out == '0)

endmodule

bind fifo_tlb_pid_page_unit ftlb_checker u_ftlb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_hit         (rsp.hit),
	.rsp_frame_out   (rsp.frame_out),
	.rsp_access_count(rsp.access_count),
	.rsp_hit_count   (rsp.hit_count)
);

`default_nettype wire
